[design/gaussian_kernel_generator_top_assert.svh]
// assertion macros for the gaussian kernel generator
// used by the top level, which supplies clk and rst_n in scope
`ifndef GAUSSIAN_KERNEL_GENERATOR_TOP_ASSERT_SVH
`define GAUSSIAN_KERNEL_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define GKG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gkg assertion failed");

// next-cycle implication
`define GKG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gkg assertion failed");

`endif

[design/gkg_pkg.sv]
// types and constants shared by the gaussian kernel generator modules
// no dependencies
`default_nettype none

package gkg_pkg;

    localparam int NUM_W  = 46;     // divider dividend width
    localparam int DEN_W  = 37;     // divider divisor width
    localparam int Q_W    = 31;     // q30 value up to 1.0
    localparam int T_W    = 29;     // exponent argument, below 0.5 in q30
    localparam int PROD_W = 62;
    localparam int SUM_W  = 37;     // up to 64 taps of q30
    localparam int DCNT_W = 6;

    localparam logic [Q_W-1:0] Q30_ONE = Q_W'(64'd1 << 30);
    localparam logic [3:0] HORNER_TERMS = 4'd8;
    localparam logic [2:0] SQUARE_LAST  = 3'd5;

    typedef enum logic [1:0] {
        DIV_A,
        DIV_K,
        DIV_W
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S2,
        ST_A_START,
        ST_A_WAIT,
        ST_H_MUL,
        ST_H_START,
        ST_H_WAIT,
        ST_Q_MUL,
        ST_Q_TAKE,
        ST_STORE,
        ST_N_RD,
        ST_N_START,
        ST_N_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic     load;
        logic     calc_s2;
        logic     exp_init;
        logic     div_start;
        div_sel_t div_sel;
        logic     a_take;
        logic     h_mul;
        logic     h_take;
        logic     sq_mul;
        logic     sq_take;
        logic     store;
        logic     rd;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic a_big;
        logic k_last;
        logic sq_last;
        logic i_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[design/gkg_div.sv]
// restoring divider, one quotient bit per cycle
// depends on gkg_pkg
`default_nettype none

module gkg_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [gkg_pkg::NUM_W-1:0] dividend,
    input  wire logic [gkg_pkg::DEN_W-1:0] divisor,
    output logic                           done,
    output logic [gkg_pkg::NUM_W-1:0]      quotient
);
    import gkg_pkg::*;

    logic [NUM_W-1:0]  dvd_reg, dvd_next;
    logic [DEN_W-1:0]  dvs_reg;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic              fits;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[NUM_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = DCNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DEN_W'(trial - {1'b0, dvs_reg}) : trial[DEN_W-1:0];
            dvd_next = {dvd_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

[design/gkg_datapath.sv]
// datapath: operand registers, multiplier, weight store, divider, output register
// depends on gkg_pkg and gkg_div
`default_nettype none

module gkg_datapath #(
    parameter int MAX_TAPS = 32,
    parameter int IW       = 5
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [5:0]       tap_count,
    input  wire logic [11:0]      sigma_q4_8,
    input  wire gkg_pkg::cmd_t    cmd,
    output gkg_pkg::status_t      status,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [4:0]            out_index,
    output logic [15:0]           out_weight,
    output logic                  out_last
);
    import gkg_pkg::*;

    logic [IW-1:0]     nlast_reg;
    logic [11:0]       s_reg;
    logic [23:0]       s2_reg;
    logic [IW-1:0]     i_reg;
    logic [3:0]        k_reg;
    logic [2:0]        sqc_reg;
    logic [T_W-1:0]    t_reg;
    logic [Q_W-1:0]    q_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [Q_W-1:0]    rd_reg;
    logic [Q_W-1:0]    e_mem [MAX_TAPS];
    logic              out_valid_reg;
    logic [4:0]        out_index_reg;
    logic [15:0]       out_weight_reg;
    logic              out_last_reg;

    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [NUM_W-1:0]  div_quo;
    logic [2*IW-1:0]   i_sq;
    logic [Q_W-1:0]    e_val;
    logic              i_last;
    logic [6:0]        tc_ext;
    logic [IW-1:0]     nlast_in;
    logic [PROD_W-1:0] sq_round;

    assign i_sq     = i_reg * i_reg;
    assign i_last   = i_reg == nlast_reg;
    assign e_val    = (i_reg == '0) ? (q_reg >> 1) : q_reg;
    assign sq_round = prod_reg + PROD_W'(64'd1 << 29);
    assign tc_ext   = {1'b0, tap_count};

    always_comb
    begin
        if (tap_count == 6'd0)
        begin
            nlast_in = '0;
        end
        else if (tc_ext > 7'(MAX_TAPS))
        begin
            nlast_in = IW'(MAX_TAPS - 1);
        end
        else
        begin
            nlast_in = IW'(tap_count - 6'd1);
        end
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_A:
            begin
                div_num = (NUM_W'(i_sq) << 31) + NUM_W'(s2_reg >> 1);
                div_den = DEN_W'(s2_reg);
            end
            DIV_K:
            begin
                div_num = NUM_W'(prod_reg[59:30]);
                div_den = DEN_W'(k_reg);
            end
            DIV_W:
            begin
                div_num = (NUM_W'(rd_reg) << 15) + NUM_W'(sum_reg >> 1);
                div_den = DEN_W'(sum_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = DEN_W'(1);
            end
        endcase
    end

    gkg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg     <= (sigma_q4_8 == 12'd0) ? 12'd1 : sigma_q4_8;
            nlast_reg <= nlast_in;
        end
        if (cmd.calc_s2)
        begin
            s2_reg <= s_reg * s_reg;
        end
        if (cmd.exp_init)
        begin
            q_reg   <= Q30_ONE;
            k_reg   <= HORNER_TERMS;
            sqc_reg <= '0;
        end
        if (cmd.a_take)
        begin
            if (status.a_big)
            begin
                q_reg <= '0;
            end
            else
            begin
                t_reg <= {div_quo[20:0], 8'd0};
            end
        end
        if (cmd.h_mul)
        begin
            prod_reg <= PROD_W'(t_reg * q_reg);
        end
        if (cmd.h_take)
        begin
            q_reg <= Q30_ONE - div_quo[Q_W-1:0];
            k_reg <= k_reg - 4'd1;
        end
        if (cmd.sq_mul)
        begin
            prod_reg <= PROD_W'(q_reg * q_reg);
        end
        if (cmd.sq_take)
        begin
            q_reg   <= sq_round[60:30];
            sqc_reg <= sqc_reg + 3'd1;
        end
        if (cmd.store)
        begin
            e_mem[i_reg] <= e_val;
        end
        if (cmd.rd)
        begin
            rd_reg <= e_mem[i_reg];
        end
        if (cmd.emit)
        begin
            out_index_reg  <= 5'(i_reg);
            out_weight_reg <= div_quo[15:0];
            out_last_reg   <= i_last;
        end
    end

    // tap counter, running sum and output valid flag are control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                i_reg   <= '0;
                sum_reg <= '0;
            end
            else if (cmd.store || cmd.emit)
            begin
                i_reg <= i_last ? '0 : i_reg + 1'b1;
            end
            if (cmd.store)
            begin
                sum_reg <= sum_reg + SUM_W'(e_val);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.div_done = div_done;
    assign status.a_big    = |div_quo[NUM_W-1:21];
    assign status.k_last   = k_reg == 4'd1;
    assign status.sq_last  = sqc_reg == SQUARE_LAST;
    assign status.i_last   = i_last;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign out_weight = out_weight_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

[design/gkg_ctrl.sv]
// controller state machine sequencing exp, sum and normalize per tap
// depends on gkg_pkg
`default_nettype none

module gkg_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire gkg_pkg::status_t status,
    output gkg_pkg::cmd_t         cmd
);
    import gkg_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_S2;
            ST_S2:      state_next = ST_A_START;
            ST_A_START: state_next = ST_A_WAIT;
            ST_A_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = status.a_big ? ST_STORE : ST_H_MUL;
                end
            end
            ST_H_MUL:   state_next = ST_H_START;
            ST_H_START: state_next = ST_H_WAIT;
            ST_H_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = status.k_last ? ST_Q_MUL : ST_H_MUL;
                end
            end
            ST_Q_MUL:   state_next = ST_Q_TAKE;
            ST_Q_TAKE:  state_next = status.sq_last ? ST_STORE : ST_Q_MUL;
            ST_STORE:   state_next = status.i_last ? ST_N_RD : ST_A_START;
            ST_N_RD:    state_next = ST_N_START;
            ST_N_START: state_next = ST_N_WAIT;
            ST_N_WAIT:  if (status.div_done) state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.i_last ? ST_IDLE : ST_N_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = DIV_A;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_S2:      cmd.calc_s2 = 1'b1;
            ST_A_START:
            begin
                cmd.div_start = 1'b1;
                cmd.exp_init  = 1'b1;
            end
            ST_A_WAIT:  cmd.a_take = status.div_done;
            ST_H_MUL:   cmd.h_mul = 1'b1;
            ST_H_START:
            begin
                cmd.div_sel   = DIV_K;
                cmd.div_start = 1'b1;
            end
            ST_H_WAIT:
            begin
                cmd.div_sel = DIV_K;
                cmd.h_take  = status.div_done;
            end
            ST_Q_MUL:   cmd.sq_mul = 1'b1;
            ST_Q_TAKE:  cmd.sq_take = 1'b1;
            ST_STORE:   cmd.store = 1'b1;
            ST_N_RD:    cmd.rd = 1'b1;
            ST_N_START:
            begin
                cmd.div_sel   = DIV_W;
                cmd.div_start = 1'b1;
            end
            ST_N_WAIT:  cmd.div_sel = DIV_W;
            ST_EMIT:
            begin
                cmd.div_sel = DIV_W;
                cmd.emit    = status.out_free;
            end
            default:    cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[design/gaussian_kernel_generator_top.sv]
// gaussian kernel generator top level
// usage: a request on s_axis carries a tap count and a sigma; the block answers with one
// transfer per tap on m_axis, distance 0 upward, tlast on the final tap.
// each tap first runs through exponent division, an 8-term horner series and six
// squarings; when the exponent is too large the series and squarings are skipped and
// the weight is zero. then the weights are normalized one at a time. all divisions
// share one restoring divider that produces one quotient bit per cycle.
// s_axis_tready is high only while no request is in progress; the next request can be
// taken while the last result still waits in the output register.
// when m_axis_tready is low the normalize phase stalls with the result held; nothing
// is lost. reset returns the controller to idle and empties the output register.
// depends on gkg_pkg, gkg_ctrl, gkg_datapath and the assertion macro header
`default_nettype none

module gaussian_kernel_generator_top #(
    parameter int MAX_TAPS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // tap_count[5:0], sigma_q4_8[17:6], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // tap_index[4:0], weight_q1_15[20:5], zero pad
    output logic             m_axis_tlast
);
    import gkg_pkg::*;

    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    cmd_t        cmd;
    status_t     status;
    logic [4:0]  out_index;
    logic [15:0] out_weight;

    gkg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gkg_datapath #(
        .MAX_TAPS (MAX_TAPS),
        .IW       (IW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .tap_count  (s_axis_tdata[5:0]),
        .sigma_q4_8 (s_axis_tdata[17:6]),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_index  (out_index),
        .out_weight (out_weight),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, out_weight, out_index};

`include "gaussian_kernel_generator_top_assert.svh"

    `GKG_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `GKG_ASSERT_IMP(a_emit_has_room, cmd.emit, status.out_free)
    `GKG_ASSERT_IMP(a_weight_range, m_axis_tvalid, m_axis_tdata[20:5] <= 16'd32768)

endmodule

`default_nettype wire

[tb/gaussian_kernel_generator_top_tb.sv]
// self-checking testbench for gaussian_kernel_generator_top
// directed table then random requests; untyped ones checked against a local predictor
// depends on gaussian_kernel_generator_top and its design files
`timescale 1ns / 100ps

module gaussian_kernel_generator_top_tb;

    localparam int MAX_TAPS    = 32;
    localparam int WDOG_LIMIT  = 120000;
    localparam int N_RANDOM    = 456;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 600;

    typedef struct {
        logic [4:0]  idx;
        logic [15:0] weight;
        logic        last;
    } tap_t;

    typedef struct {
        logic [5:0]  count;
        logic [11:0] sigma;
        bit          typed;   // expected: center 32768, others 0
    } req_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    tap_t tap_q[$];
    int   errors;
    int   sent;
    int   idle_mode;
    int   hold_left;
    bit   hold_done;
    int   quiet;

    gaussian_kernel_generator_top #(.MAX_TAPS(MAX_TAPS)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // exp(-a) for a in q16, result in q30
    function automatic longint unsigned exp_q30(input longint unsigned a);
        longint unsigned t;
        longint unsigned q;
        q = 64'd1 << 30;
        if (a >= (64'd32 << 16))
            return 0;
        t = a << 8;
        for (int k = 8; k >= 1; k--)
            q = (64'd1 << 30) - (((t * q) >> 30) / k);
        for (int k = 0; k < 6; k++)
            q = (q * q + (64'd1 << 29)) >> 30;
        return q;
    endfunction

    task automatic predict_kernel(input logic [5:0] count, input logic [11:0] sigma);
        longint unsigned e[MAX_TAPS];
        longint unsigned n;
        longint unsigned s;
        longint unsigned s2;
        longint unsigned total;
        longint unsigned num;
        tap_t t;
        n = (count == 0) ? 1 : count;
        if (n > MAX_TAPS)
            n = MAX_TAPS;
        s = (sigma == 0) ? 1 : sigma;
        s2 = s * s;
        total = 0;
        for (int i = 0; i < n; i++)
        begin
            num = (longint'(i) * i) << 31;
            e[i] = exp_q30((num + s2 / 2) / s2);
        end
        e[0] = e[0] / 2;
        for (int i = 0; i < n; i++)
            total += e[i];
        for (int i = 0; i < n; i++)
        begin
            t.idx = i[4:0];
            t.weight = 16'(((e[i] << 15) + total / 2) / total);
            t.last = (i + 1 == n);
            tap_q.push_back(t);
        end
    endtask

    task automatic push_typed(input logic [5:0] count);
        int   n;
        tap_t t;
        n = (count == 0) ? 1 : ((count > MAX_TAPS) ? MAX_TAPS : count);
        for (int i = 0; i < n; i++)
        begin
            t.idx = i[4:0];
            t.weight = (i == 0) ? 16'd32768 : 16'd0;
            t.last = (i + 1 == n);
            tap_q.push_back(t);
        end
    endtask

    task automatic send_request(input req_t r);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 24 : ((idle_mode == 1) ? 65 : 0);
        while ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, r.sigma, r.count};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (r.typed)
            push_typed(r.count);
        else
            predict_kernel(r.count, r.sigma);
        sent++;
    endtask

    // receiver with random stalls, one long hold-off, and the result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (tap_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer idx %0d weight %0d last %0b", $time,
                             m_axis_tdata[4:0], m_axis_tdata[20:5], m_axis_tlast);
                    errors++;
                end
                else
                begin
                    tap_t x;
                    x = tap_q.pop_front();
                    if (m_axis_tdata[4:0] !== x.idx || m_axis_tdata[20:5] !== x.weight
                        || m_axis_tlast !== x.last)
                    begin
                        $display("%0t: mismatch expected idx %0d weight %0d last %0b, got idx %0d weight %0d last %0b",
                                 $time, x.idx, x.weight, x.last, m_axis_tdata[4:0],
                                 m_axis_tdata[20:5], m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (!hold_done && sent == 40)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= $urandom_range(99) >=
                                 ((idle_mode == 0) ? 65 : ((idle_mode == 1) ? 24 : 0));
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WDOG_LIMIT)
        begin
            $display("gaussian_kernel_generator_top_tb failed");
            $finish;
        end
    end

    initial
    begin
        req_t directed[$];
        req_t r;
        int   pick;
        errors = 0;
        sent = 0;
        quiet = 0;
        idle_mode = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        directed = '{
            '{6'd1,  12'd256,  1'b1},
            '{6'd0,  12'd256,  1'b1},
            '{6'd3,  12'd0,    1'b1},
            '{6'd1,  12'd4095, 1'b1},
            '{6'd32, 12'd0,    1'b1},
            '{6'd32, 12'd256,  1'b0},
            '{6'd63, 12'd2560, 1'b0},
            '{6'd32, 12'd4095, 1'b0},
            '{6'd2,  12'd256,  1'b0},
            '{6'd5,  12'd2560, 1'b0},
            '{6'd8,  12'd1,    1'b0},
            '{6'd16, 12'd1024, 1'b0},
            '{6'd4,  12'd384,  1'b0},
            '{6'd6,  12'd2048, 1'b0}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_request(directed[i]);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            idle_mode = (i < 150) ? 0 : ((i < 300) ? 1 : 2);
            if (i == 200)
            begin
                s_axis_tvalid <= 1'b0;
                wait (tap_q.size() == 0);
                @(posedge clk);
            end
            pick = $urandom_range(99);
            // mostly short kernels keep the run length reasonable
            if (pick < 4)
                r.count = 6'($urandom_range(63, 24));
            else if (pick < 14)
                r.count = 6'($urandom_range(12, 5));
            else
                r.count = 6'($urandom_range(4, 0));
            r.sigma = ($urandom_range(99) < 20) ? 12'($urandom_range(4095))
                                                : 12'($urandom_range(2560, 256));
            r.typed = 1'b0;
            send_request(r);
        end
        s_axis_tvalid <= 1'b0;
        wait (tap_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && tap_q.size() == 0)
            $display("gaussian_kernel_generator_top_tb passed");
        else
            $display("gaussian_kernel_generator_top_tb failed");
        $finish;
    end

endmodule
